// ----- sv/signed_bcd_fixed_point_adder_macros.svh -----
// Assertion macros for the signed BCD fixed-point adder.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SIGNED_BCD_FIXED_POINT_ADDER_MACROS_SVH
`define SIGNED_BCD_FIXED_POINT_ADDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sbfa_pkg.sv -----
// Package for the signed BCD fixed-point adder: digit counts, widths,
// the count struct and BCD digit helpers. No dependencies.
package sbfa_pkg;

  localparam int INT_DIGITS  = 8;
  localparam int FRAC_DIGITS = 8;
  localparam int ALL_DIGITS  = INT_DIGITS + FRAC_DIGITS;
  localparam int DIGIT_W     = 4;
  localparam int INT_W       = INT_DIGITS * DIGIT_W;
  localparam int FRAC_W      = FRAC_DIGITS * DIGIT_W;
  localparam int MAG_W       = ALL_DIGITS * DIGIT_W;
  localparam int SUM_INT_W   = (INT_DIGITS + 1) * DIGIT_W;
  localparam int RES_W       = MAG_W + DIGIT_W;
  localparam int CNT_W       = 4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
  localparam logic [DIGIT_W-1:0] BCD_BIAS  = DIGIT_W'(6);

  typedef struct packed {
    logic [CNT_W-1:0] frac_cnt;
    logic [CNT_W-1:0] int_cnt;
  } sbfa_counts_t;

  // Nibble is not a decimal digit.
  function automatic logic digit_bad(input logic [DIGIT_W-1:0] d);
    return d > DIGIT_MAX;
  endfunction

  // Nine's complement of every digit of a magnitude.
  function automatic logic [MAG_W-1:0] nines_comp(input logic [MAG_W-1:0] m);
    logic [MAG_W-1:0] r;
    r = '0;
    for (int k = 0; k < ALL_DIGITS; k++) begin
      r[k*DIGIT_W +: DIGIT_W] = DIGIT_MAX - m[k*DIGIT_W +: DIGIT_W];
    end
    return r;
  endfunction

endpackage

// ----- sv/sbfa_bcd_adder.sv -----
// Packed-BCD adder over the full magnitude width, with carry in and out.
// Depends on sbfa_pkg.
module sbfa_bcd_adder (
  input  logic [sbfa_pkg::MAG_W-1:0] x,
  input  logic [sbfa_pkg::MAG_W-1:0] y,
  input  logic                       cin,
  output logic [sbfa_pkg::MAG_W-1:0] sum,
  output logic                       cout
);
  import sbfa_pkg::*;

  logic [MAG_W-1:0] biased;
  logic [MAG_W:0]   raw;
  logic [MAG_W:0]   carries;

  // Pre-bias every digit by six so the binary carries land on digit edges.
  always_comb begin
    for (int k = 0; k < ALL_DIGITS; k++) begin
      biased[k*DIGIT_W +: DIGIT_W] = x[k*DIGIT_W +: DIGIT_W] + BCD_BIAS;
    end
  end

  assign raw     = {1'b0, biased} + {1'b0, y} + {{MAG_W{1'b0}}, cin};
  assign carries = {1'b0, biased} ^ {1'b0, y} ^ raw;

  // Digits that produced no decimal carry still hold the bias; take it out.
  always_comb begin
    for (int k = 0; k < ALL_DIGITS; k++) begin
      if (carries[(k+1)*DIGIT_W]) begin
        sum[k*DIGIT_W +: DIGIT_W] = raw[k*DIGIT_W +: DIGIT_W];
      end else begin
        sum[k*DIGIT_W +: DIGIT_W] = raw[k*DIGIT_W +: DIGIT_W] - BCD_BIAS;
      end
    end
  end

  assign cout = raw[MAG_W];

endmodule

// ----- sv/sbfa_digit_count.sv -----
// Fraction and integer significant-digit counts of a BCD result.
// Depends on sbfa_pkg.
module sbfa_digit_count (
  input  logic [sbfa_pkg::RES_W-1:0] res,
  output sbfa_pkg::sbfa_counts_t     counts
);
  import sbfa_pkg::*;

  always_comb begin
    counts.frac_cnt = '0;
    // Lowest nonzero fraction digit sets the count; scan downward so it wins.
    for (int k = FRAC_DIGITS - 1; k >= 0; k--) begin
      if (res[k*DIGIT_W +: DIGIT_W] != '0) begin
        counts.frac_cnt = CNT_W'(FRAC_DIGITS - k);
      end
    end
    counts.int_cnt = CNT_W'(1);
    for (int k = 0; k <= INT_DIGITS; k++) begin
      if (res[FRAC_W + k*DIGIT_W +: DIGIT_W] != '0) begin
        counts.int_cnt = CNT_W'(k + 1);
      end
    end
  end

endmodule

// ----- sv/signed_bcd_fixed_point_adder.sv -----
// Signed BCD fixed-point adder, top level. Uses sbfa_pkg, sbfa_bcd_adder,
// sbfa_digit_count and the assertion macros header.
//
// Adds two sign-magnitude decimal numbers of eight packed-BCD integer digits
// and eight fraction digits. Equal signs add magnitudes (integer part may grow
// to nine digits); opposite signs subtract the smaller magnitude from the
// larger and keep the larger operand's sign; a zero result is always
// positive. Any nibble above nine forces an all-zero result with invalid set
// and int_digit_count 1. Timing: an operand pair is captured in an input
// register, goes through one pass of BCD adders and digit counting, and lands
// in the output register; one transfer is accepted every cycle while in_stall
// is low. Three 16-digit BCD adders work in
// parallel (sum, a minus b, b minus a); the carry out of a minus b picks the
// larger magnitude, so the longest path is one 64-bit carry chain followed by
// a mux and the digit counters. in_stall only rises when both registers are
// full and the output is stalled. No state beyond the pipeline valid bits.
`include "signed_bcd_fixed_point_adder_macros.svh"

module signed_bcd_fixed_point_adder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_a_negative,
  input  logic [sbfa_pkg::INT_W-1:0]     in_a_int,
  input  logic [sbfa_pkg::FRAC_W-1:0]    in_a_frac,
  input  logic                           in_b_negative,
  input  logic [sbfa_pkg::INT_W-1:0]     in_b_int,
  input  logic [sbfa_pkg::FRAC_W-1:0]    in_b_frac,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_sum_negative,
  output logic [sbfa_pkg::SUM_INT_W-1:0] out_sum_int,
  output logic [sbfa_pkg::FRAC_W-1:0]    out_sum_frac,
  output logic [sbfa_pkg::CNT_W-1:0]     out_frac_digit_count,
  output logic [sbfa_pkg::CNT_W-1:0]     out_int_digit_count,
  output logic                           out_invalid
);
  import sbfa_pkg::*;

  // Input register
  logic             in_valid_r;
  logic             a_neg_r, b_neg_r;
  logic [MAG_W-1:0] a_mag_r, b_mag_r;

  // Output register
  logic                 out_valid_r;
  logic                 sum_neg_r;
  logic [RES_W-1:0]     res_r;
  logic                 invalid_r;
  sbfa_counts_t         counts_r;

  logic             out_adv;
  logic             in_take;

  // Combinational datapath
  logic             bad;
  logic [MAG_W-1:0] sum_mag, dab_mag, dba_mag;
  logic             sum_cout, dab_cout, dba_cout;
  logic [RES_W-1:0] res_nxt;
  logic             sum_neg_nxt;
  sbfa_counts_t     counts_nxt;

  // Output register loads when empty or when its content transfers out;
  // the input register loads when empty or when it hands off.
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_take  = !in_valid_r || out_adv;
  assign in_stall = !in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      a_neg_r <= in_a_negative;
      b_neg_r <= in_b_negative;
      a_mag_r <= {in_a_int, in_a_frac};
      b_mag_r <= {in_b_int, in_b_frac};
    end
  end

  // Any non-decimal nibble in either operand
  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < ALL_DIGITS; k++) begin
      if (digit_bad(a_mag_r[k*DIGIT_W +: DIGIT_W]) ||
          digit_bad(b_mag_r[k*DIGIT_W +: DIGIT_W])) begin
        bad = 1'b1;
      end
    end
  end

  sbfa_bcd_adder u_add_sum (
    .x    (a_mag_r),
    .y    (b_mag_r),
    .cin  (1'b0),
    .sum  (sum_mag),
    .cout (sum_cout)
  );

  // Ten's complement subtraction; carry out set means minuend >= subtrahend
  sbfa_bcd_adder u_sub_ab (
    .x    (a_mag_r),
    .y    (nines_comp(b_mag_r)),
    .cin  (1'b1),
    .sum  (dab_mag),
    .cout (dab_cout)
  );

  sbfa_bcd_adder u_sub_ba (
    .x    (b_mag_r),
    .y    (nines_comp(a_mag_r)),
    .cin  (1'b1),
    .sum  (dba_mag),
    .cout (dba_cout)
  );

  always_comb begin
    if (a_neg_r == b_neg_r) begin
      res_nxt     = {{(DIGIT_W-1){1'b0}}, sum_cout, sum_mag};
      sum_neg_nxt = a_neg_r;
    end else if (dab_cout) begin
      res_nxt     = {{DIGIT_W{1'b0}}, dab_mag};
      sum_neg_nxt = a_neg_r;
    end else begin
      // b strictly larger; dba_cout is set here
      res_nxt     = {{DIGIT_W{1'b0}}, dba_mag};
      sum_neg_nxt = b_neg_r | !dba_cout;
    end
    if (bad) begin
      res_nxt = '0;
    end
    // no minus zero
    if (res_nxt == '0) begin
      sum_neg_nxt = 1'b0;
    end
  end

  sbfa_digit_count u_count (
    .res    (res_nxt),
    .counts (counts_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid_r) begin
      sum_neg_r <= sum_neg_nxt;
      res_r     <= res_nxt;
      invalid_r <= bad;
      counts_r  <= counts_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sum_negative     = sum_neg_r;
  assign out_sum_int          = res_r[RES_W-1:FRAC_W];
  assign out_sum_frac         = res_r[FRAC_W-1:0];
  assign out_frac_digit_count = counts_r.frac_cnt;
  assign out_int_digit_count  = counts_r.int_cnt;
  assign out_invalid          = invalid_r;

  // Checks on the result register
  `SBFA_ASSERT_NOW(a_invalid_zeroes, clk, rst_n, out_valid_r && invalid_r, res_r == '0 && !sum_neg_r && counts_r.int_cnt == CNT_W'(1) && counts_r.frac_cnt == '0, "invalid result not cleared")
  `SBFA_ASSERT_NOW(a_no_minus_zero, clk, rst_n, out_valid_r && sum_neg_r, res_r != '0, "negative zero result")
  `SBFA_ASSERT_NOW(a_frac_cnt_zero, clk, rst_n, out_valid_r, (counts_r.frac_cnt == '0) == (res_r[FRAC_W-1:0] == '0), "fraction count disagrees with fraction")
  `SBFA_ASSERT_NEXT(a_result_loaded, clk, rst_n, in_valid_r && out_adv, out_valid_r, "input register did not hand off")

endmodule
